[hdl/fifo_scheduler_with_cancel_defines.svh]
// Assertion macros shared by the scheduler RTL files.
// Included by fsc_ctrl and fifo_scheduler_with_cancel; no other dependencies.
`ifndef FIFO_SCHEDULER_WITH_CANCEL_DEFINES_SVH
`define FIFO_SCHEDULER_WITH_CANCEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSC_CHECK(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSC_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fsc_pkg.sv]
// Package for the FIFO scheduler with cancel: codes, port widths, FSM states
// and the result bundle. No dependencies.
package fsc_pkg;

  localparam int DEF_SLOTS   = 16;
  localparam int DEF_ID_BITS = 16;

  localparam int ID_PORT_W   = 16;
  localparam int CNT_PORT_W  = 5;
  localparam int OUT_TDATA_W = 40;

  // Action codes; the fourth code is a no-op.
  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_TERM = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_RUN_RD,
    S_TERM_RD,
    S_TERM_CMP,
    S_UNLINK,
    S_REP_RD,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [CNT_PORT_W-1:0] task_count;
    logic                  queue_empty;
    logic [ID_PORT_W-1:0]  oldest_id;
    logic [1:0]            status;
    logic [ID_PORT_W-1:0]  result_id;
  } result_t;

endpackage

[hdl/fsc_slot_mem.sv]
// Slot table storage: identifier, newer-link and older-link memories with
// one write port each and a shared registered read port. Uses no package.
module fsc_slot_mem #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16,
  localparam int IW     = $clog2(SLOTS)
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [IW-1:0]      rd_addr,
  output logic [ID_BITS-1:0] rd_id,
  output logic [IW-1:0]      rd_newer,
  output logic [IW-1:0]      rd_older,
  input  logic               id_we,
  input  logic [IW-1:0]      id_waddr,
  input  logic [ID_BITS-1:0] id_wdata,
  input  logic               nl_we,
  input  logic [IW-1:0]      nl_waddr,
  input  logic [IW-1:0]      nl_wdata,
  input  logic               ol_we,
  input  logic [IW-1:0]      ol_waddr,
  input  logic [IW-1:0]      ol_wdata
);

  logic [ID_BITS-1:0] id_mem    [SLOTS];
  logic [IW-1:0]      newer_mem [SLOTS];
  logic [IW-1:0]      older_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_waddr] <= id_wdata;
    end
    if (nl_we) begin
      newer_mem[nl_waddr] <= nl_wdata;
    end
    if (ol_we) begin
      older_mem[ol_waddr] <= ol_wdata;
    end
  end

  // Read data holds while rd_en is low so a fetched slot survives a compare.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id    <= id_mem[rd_addr];
      rd_newer <= newer_mem[rd_addr];
      rd_older <= older_mem[rd_addr];
    end
  end

endmodule

[hdl/fsc_ctrl.sv]
// Sequencer of the scheduler: free-slot scan, identifier compare over the
// slots, list unlink and result assembly. Depends on fsc_pkg and the defines.
`include "fifo_scheduler_with_cancel_defines.svh"

module fsc_ctrl #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16,
  localparam int IW     = $clog2(SLOTS),
  localparam int CW     = $clog2(SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [fsc_pkg::ID_PORT_W-1:0] in_task_id,
  output logic                 rd_en,
  output logic [IW-1:0]        rd_addr,
  input  logic [ID_BITS-1:0]   rd_id,
  input  logic [IW-1:0]        rd_newer,
  input  logic [IW-1:0]        rd_older,
  output logic                 id_we,
  output logic [IW-1:0]        id_waddr,
  output logic [ID_BITS-1:0]   id_wdata,
  output logic                 nl_we,
  output logic [IW-1:0]        nl_waddr,
  output logic [IW-1:0]        nl_wdata,
  output logic                 ol_we,
  output logic [IW-1:0]        ol_waddr,
  output logic [IW-1:0]        ol_wdata,
  output logic                 res_valid,
  input  logic                 res_ready,
  output fsc_pkg::result_t     res
);

  import fsc_pkg::*;

  state_t             state_r,   state_nxt;
  logic [ID_BITS-1:0] want_r,    want_nxt;
  logic [IW-1:0]      scan_r,    scan_nxt;
  logic [SLOTS-1:0]   used_r,    used_nxt;
  logic [IW-1:0]      oldest_r,  oldest_nxt;
  logic [IW-1:0]      newest_r,  newest_nxt;
  logic [CW-1:0]      count_r,   count_nxt;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;
  logic [ID_BITS-1:0] res_id_r,  res_id_nxt;
  logic [1:0]         status_r,  status_nxt;
  logic               id_hit;

  // The single compare unit, reused for every slot of a terminate scan.
  assign id_hit = used_r[scan_r] && (rd_id == want_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      oldest_r  <= '0;
      newest_r  <= '0;
      count_r   <= '0;
      next_id_r <= '0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      oldest_r  <= oldest_nxt;
      newest_r  <= newest_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r   <= want_nxt;
    scan_r   <= scan_nxt;
    res_id_r <= res_id_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    want_nxt    = want_r;
    scan_nxt    = scan_r;
    used_nxt    = used_r;
    oldest_nxt  = oldest_r;
    newest_nxt  = newest_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    res_id_nxt  = res_id_r;
    status_nxt  = status_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = scan_r;
    id_we       = 1'b0;
    id_waddr    = scan_r;
    id_wdata    = next_id_r;
    nl_we       = 1'b0;
    nl_waddr    = newest_r;
    nl_wdata    = scan_r;
    ol_we       = 1'b0;
    ol_waddr    = scan_r;
    ol_wdata    = newest_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          want_nxt   = ID_BITS'(in_task_id);
          scan_nxt   = '0;
          res_id_nxt = '0;
          status_nxt = ST_OK;
          case (in_action)
            ACT_ADD: begin
              if (count_r == CW'(SLOTS)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_REP_RD;
              end else begin
                state_nxt = S_FIND;
              end
            end
            ACT_RUN: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_REP_RD;
              end else begin
                scan_nxt  = oldest_r;
                state_nxt = S_RUN_RD;
              end
            end
            ACT_TERM: begin
              state_nxt = S_TERM_RD;
            end
            default: begin
              state_nxt = S_REP_RD;
            end
          endcase
        end
      end

      S_FIND: begin
        // A free slot exists here, since the count is below the table size.
        if (!used_r[scan_r]) begin
          id_we            = 1'b1;
          used_nxt[scan_r] = 1'b1;
          res_id_nxt       = next_id_r;
          next_id_nxt      = next_id_r + 1'b1;
          if (count_r == '0) begin
            oldest_nxt = scan_r;
          end else begin
            nl_we = 1'b1;
            ol_we = 1'b1;
          end
          newest_nxt = scan_r;
          count_nxt  = count_r + 1'b1;
          state_nxt  = S_REP_RD;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_RUN_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_UNLINK;
      end

      S_TERM_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_TERM_CMP;
      end

      S_TERM_CMP: begin
        if (id_hit) begin
          state_nxt = S_UNLINK;
        end else if (scan_r == IW'(SLOTS - 1)) begin
          status_nxt = ST_UNKNOWN;
          state_nxt  = S_REP_RD;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_TERM_RD;
        end
      end

      S_UNLINK: begin
        res_id_nxt       = rd_id;
        used_nxt[scan_r] = 1'b0;
        if (count_r <= CW'(1)) begin
          count_nxt = '0;
        end else begin
          count_nxt = count_r - 1'b1;
          if (scan_r == oldest_r) begin
            oldest_nxt = rd_newer;
          end else if (scan_r == newest_r) begin
            newest_nxt = rd_older;
          end else begin
            nl_we    = 1'b1;
            nl_waddr = rd_older;
            nl_wdata = rd_newer;
            ol_we    = 1'b1;
            ol_waddr = rd_newer;
            ol_wdata = rd_older;
          end
        end
        state_nxt = S_REP_RD;
      end

      S_REP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = oldest_r;
        state_nxt = S_REPORT;
      end

      S_REPORT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.result_id   = ID_PORT_W'(res_id_r);
    res.status      = status_r;
    res.oldest_id   = (count_r != '0) ? ID_PORT_W'(rd_id) : '0;
    res.queue_empty = (count_r == '0);
    res.task_count  = CNT_PORT_W'(count_r);
  end

  `FSC_CHECK(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(SLOTS), "count above table size")
  `FSC_CHECK(a_used_vs_count, clk, rst_n, 1'b1, $countones(used_r) == int'(count_r), "used bits disagree with count")
  `FSC_CHECK_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "second item taken while busy")

endmodule

[hdl/fifo_scheduler_with_cancel.sv]
// Top level of the FIFO task scheduler with cancel by identifier.
// Instantiates fsc_ctrl and fsc_slot_mem; uses fsc_pkg and the defines header.
//
//  Channel | Ports                        | Contents
//  --------+------------------------------+-----------------------------------
//  input   | in_tvalid/in_tready          | in_tuser: action, in_tdata: task_id
//  result  | out_tvalid/out_tready        | out_tdata: result_id .. task_count
//
// One item is worked on at a time; the sequencer steps through the slot table
// with a single compare unit and one read port on the slot memories.
// An add scans upward for the lowest free slot; a run reads the oldest slot;
// a terminate reads and compares the slots in turn from slot 0 until a match
// or the last slot; a full add, a run on an empty queue and the unused action
// go straight to the report.
// Reset (rst_n low, synchronous) empties the queue and zeroes the identifier
// counter; slot memories are not cleared and their data is used only for used slots.
// The result sits in an output register, so a stalled out_tready only holds
// the block once the next result is ready to be loaded.
`include "fifo_scheduler_with_cancel_defines.svh"

module fifo_scheduler_with_cancel #(
  parameter int SLOTS   = fsc_pkg::DEF_SLOTS,
  parameter int ID_BITS = fsc_pkg::DEF_ID_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [1:0]                      in_tuser,   // [1:0] action
  input  logic [fsc_pkg::ID_PORT_W-1:0]   in_tdata,   // [15:0] task_id
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] result_id, [17:16] status, [33:18] oldest_id, [34] queue_empty,
  // [39:35] task_count
  output logic [fsc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import fsc_pkg::*;

  localparam int IW = $clog2(SLOTS);

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic [ID_BITS-1:0] rd_id;
  logic [IW-1:0]      rd_newer;
  logic [IW-1:0]      rd_older;
  logic               id_we;
  logic [IW-1:0]      id_waddr;
  logic [ID_BITS-1:0] id_wdata;
  logic               nl_we;
  logic [IW-1:0]      nl_waddr;
  logic [IW-1:0]      nl_wdata;
  logic               ol_we;
  logic [IW-1:0]      ol_waddr;
  logic [IW-1:0]      ol_wdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  logic               out_valid_r;
  result_t            out_data_r;

  fsc_ctrl #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_task_id (in_tdata),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_id      (rd_id),
    .rd_newer   (rd_newer),
    .rd_older   (rd_older),
    .id_we      (id_we),
    .id_waddr   (id_waddr),
    .id_wdata   (id_wdata),
    .nl_we      (nl_we),
    .nl_waddr   (nl_waddr),
    .nl_wdata   (nl_wdata),
    .ol_we      (ol_we),
    .ol_waddr   (ol_waddr),
    .ol_wdata   (ol_wdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  fsc_slot_mem #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_slot_mem (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_id    (rd_id),
    .rd_newer (rd_newer),
    .rd_older (rd_older),
    .id_we    (id_we),
    .id_waddr (id_waddr),
    .id_wdata (id_wdata),
    .nl_we    (nl_we),
    .nl_waddr (nl_waddr),
    .nl_wdata (nl_wdata),
    .ol_we    (ol_we),
    .ol_waddr (ol_waddr),
    .ol_wdata (ol_wdata)
  );

  // The output register can take a new result when it is empty or draining.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FSC_CHECK(a_error_zero_id, clk, rst_n, out_valid_r && (out_data_r.status != ST_OK), out_data_r.result_id == '0, "failed item carries an identifier")

endmodule

[sim/tb_fifo_scheduler_with_cancel.sv]
// Self-checking testbench for the FIFO task scheduler with cancel by identifier.
// Depends on fsc_pkg and fifo_scheduler_with_cancel; needs no files or arguments.
`timescale 1ns / 100ps

module tb_fifo_scheduler_with_cancel;
  import fsc_pkg::*;

  localparam int SLOTS = DEF_SLOTS;

  // The fourth action code does nothing but still returns one report.
  localparam logic [1:0] ACT_NOP = 2'd3;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [1:0]             in_tuser = ACT_NOP;   // [1:0] action
  logic [ID_PORT_W-1:0]   in_tdata = '0;        // [15:0] task_id
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [15:0] result_id, [17:16] status, [33:18] oldest_id, [34] queue_empty,
  // [39:35] task_count
  logic [OUT_TDATA_W-1:0] out_tdata;

  fifo_scheduler_with_cancel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the slot table. It is updated when an item is accepted,
  // so the stimulus can also look at it to steer toward interesting cases.
  logic [15:0] tbl_id    [SLOTS];
  bit          tbl_used  [SLOTS];
  logic [3:0]  tbl_newer [SLOTS];
  logic [3:0]  tbl_older [SLOTS];
  logic [3:0]  tbl_newest;
  logic [3:0]  tbl_oldest;
  int          tbl_count;
  logic [15:0] tbl_next_id;

  // Reports that the block still owes us, oldest first.
  result_t queued_reports[$];

  // Per-cycle idle chances in percent, set by each test.
  int gap_pct   = 0;
  int stall_pct = 0;

  int errors = 0;
  int n_add = 0, n_run = 0, n_term = 0, n_nop = 0;
  int status_seen[4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block stops answering.
  initial begin
    #30000000;
    $display("Timeout: %0d reports still outstanding", queued_reports.size());
    $display("Some tests failed");
    $finish;
  end

  // Remove one used slot from the linked list. The middle case stitches the
  // neighbors together; the ends only move the head or tail pointer.
  function automatic void unlink_slot(logic [3:0] s);
    logic [3:0] o;
    logic [3:0] n;
    if (tbl_count <= 1) begin
      tbl_count = 0;
    end else if (s == tbl_oldest) begin
      tbl_oldest = tbl_newer[s];
      tbl_count--;
    end else if (s == tbl_newest) begin
      tbl_newest = tbl_older[s];
      tbl_count--;
    end else begin
      o = tbl_older[s];
      n = tbl_newer[s];
      tbl_newer[o] = n;
      tbl_older[n] = o;
      tbl_count--;
    end
    tbl_used[s] = 1'b0;
  endfunction

  // Apply one action to the shadow table and return the report it should
  // produce. A cancel scans from slot 0 up, so among duplicate identifiers
  // the lowest-numbered slot is the one cancelled.
  function automatic result_t apply_task_action(logic [1:0] act, logic [15:0] want);
    result_t r;
    int      f;
    int      s;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_ADD: begin
        f = 0;
        while (f < SLOTS && tbl_used[f]) f++;
        if (tbl_count >= SLOTS || f >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          r.result_id = tbl_next_id;
          tbl_next_id = tbl_next_id + 16'd1;
          tbl_id[f]   = r.result_id;
          tbl_used[f] = 1'b1;
          if (tbl_count == 0) begin
            tbl_oldest = 4'(f);
          end else begin
            tbl_newer[tbl_newest] = 4'(f);
            tbl_older[f]          = tbl_newest;
          end
          tbl_newest = 4'(f);
          tbl_count++;
        end
      end
      ACT_RUN: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_id = tbl_id[tbl_oldest];
          unlink_slot(tbl_oldest);
        end
      end
      ACT_TERM: begin
        s = 0;
        while (s < SLOTS && !(tbl_used[s] && tbl_id[s] == want)) s++;
        if (s >= SLOTS || tbl_count == 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          r.result_id = tbl_id[s];
          unlink_slot(4'(s));
        end
      end
      default: begin
      end
    endcase
    r.task_count  = 5'(tbl_count);
    r.queue_empty = (tbl_count == 0);
    r.oldest_id   = (tbl_count != 0) ? tbl_id[tbl_oldest] : '0;
    return r;
  endfunction

  // Present one item, holding it until the block takes it. in_tready is
  // read right after the edge, so it is the value the block saw at that edge.
  task automatic send_item(logic [1:0] act, logic [15:0] tid);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= tid;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    queued_reports.push_back(apply_task_action(act, tid));
    case (act)
      ACT_ADD:  n_add++;
      ACT_RUN:  n_run++;
      ACT_TERM: n_term++;
      default:  n_nop++;
    endcase
  endtask

  task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    errors++;
  endtask

  // Result side: random back-pressure plus a field-by-field check of every
  // report against the oldest one still owed.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (queued_reports.size() == 0) begin
          $display("%0t ns: unexpected report, expected none, got %h", $time, out_tdata);
          errors++;
        end else begin
          want = queued_reports.pop_front();
          status_seen[want.status]++;
          if (got.result_id !== want.result_id)
            report_mismatch("result_id", want.result_id, got.result_id);
          if (got.status !== want.status)
            report_mismatch("status", 16'(want.status), 16'(got.status));
          if (got.oldest_id !== want.oldest_id)
            report_mismatch("oldest_id", want.oldest_id, got.oldest_id);
          if (got.queue_empty !== want.queue_empty)
            report_mismatch("queue_empty", 16'(want.queue_empty), 16'(got.queue_empty));
          if (got.task_count !== want.task_count)
            report_mismatch("task_count", 16'(want.task_count), 16'(got.task_count));
        end
      end
    end
  end

  // Directed pass over the corners: empty queue, unused action, filling to
  // the last slot, add on a full table, cancels at the tail, the head and the
  // middle of the list, and slot reuse from the lowest free slot.
  task automatic test_basic_ops();
    int k;
    gap_pct   = 0;
    stall_pct = 0;
    send_item(ACT_RUN, 16'hFFFF);
    send_item(ACT_TERM, 16'h0000);
    send_item(ACT_NOP, 16'hA5A5);
    for (k = 0; k < SLOTS; k++) send_item(ACT_ADD, 16'(k * 16'h1111));
    send_item(ACT_ADD, 16'hFFFF);
    send_item(ACT_TERM, 16'd5);
    send_item(ACT_TERM, 16'd0);
    send_item(ACT_TERM, 16'd15);
    send_item(ACT_RUN, 16'h5A5A);
    send_item(ACT_ADD, 16'h0000);
    send_item(ACT_TERM, 16'hFFFF);
    send_item(ACT_TERM, 16'd0);
  endtask

  // Free slots out of age order, refill them so that slot order and list
  // order disagree, then cancel in the middle and at the tail and drain the
  // queue, which checks that the links still give first-come first-served.
  task automatic test_slot_reuse_order();
    gap_pct   = 0;
    stall_pct = 0;
    while (tbl_count > 0) send_item(ACT_RUN, 16'($urandom));
    repeat (SLOTS) send_item(ACT_ADD, 16'($urandom));
    send_item(ACT_TERM, tbl_id[7]);
    send_item(ACT_TERM, tbl_id[2]);
    send_item(ACT_TERM, tbl_id[11]);
    send_item(ACT_RUN, 16'($urandom));
    repeat (4) send_item(ACT_ADD, 16'($urandom));
    send_item(ACT_TERM, tbl_id[2]);
    send_item(ACT_TERM, tbl_id[11]);
    while (tbl_count > 0) send_item(ACT_RUN, 16'($urandom));
  endtask

  // Random traffic. The add share changes every few dozen items, so the
  // queue swings between empty and full. Most cancels name a waiting task;
  // the rest use a random identifier, and a few items use the unused action.
  task automatic test_random_traffic(int gap, int stall, int n_items);
    int          i;
    int          s;
    int          add_pct;
    int          roll;
    logic [1:0]  act;
    logic [15:0] tid;
    logic [15:0] live[$];
    gap_pct   = gap;
    stall_pct = stall;
    add_pct   = 50;
    for (i = 0; i < n_items; i++) begin
      if (i % 32 == 0) add_pct = $urandom_range(20, 75);
      roll = $urandom_range(99);
      tid  = 16'($urandom);
      if (roll < add_pct) begin
        act = ACT_ADD;
      end else if (roll < add_pct + (96 - add_pct) / 2) begin
        act = ACT_RUN;
      end else if (roll < 96) begin
        act = ACT_TERM;
        live.delete();
        for (s = 0; s < SLOTS; s++) begin
          if (tbl_used[s]) live.push_back(tbl_id[s]);
        end
        if (live.size() != 0 && $urandom_range(3) != 0)
          tid = live[$urandom_range(live.size() - 1)];
      end else begin
        act = ACT_NOP;
      end
      send_item(act, tid);
    end
  endtask

  initial begin
    foreach (tbl_used[k]) begin
      tbl_used[k]  = 1'b0;
      tbl_id[k]    = '0;
      tbl_newer[k] = '0;
      tbl_older[k] = '0;
    end
    tbl_newest  = '0;
    tbl_oldest  = '0;
    tbl_count   = 0;
    tbl_next_id = '0;
    foreach (status_seen[k]) status_seen[k] = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_slot_reuse_order();
    test_random_traffic(0, 0, 190);
    test_random_traffic(46, 0, 190);
    test_random_traffic(0, 46, 190);
    test_random_traffic(38, 38, 190);

    in_tvalid <= 1'b0;
    while (queued_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d adds, %0d runs, %0d cancels and %0d unused-action items;",
             n_add, n_run, n_term, n_nop);
    $display("statuses ok/unknown/full/empty %0d/%0d/%0d/%0d under idle and stall phases.",
             status_seen[ST_OK], status_seen[ST_UNKNOWN],
             status_seen[ST_FULL], status_seen[ST_EMPTY]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
